@@ design/spr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the scale pitch resolver: register codes,
// field widths, reset values, divider request and response, sequencer states.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int IW        = 32;
    localparam int NUM_W     = 24;
    localparam int DEN_W     = 16;
    localparam int CNT_W     = 5;
    localparam int NOTE_W    = 7;
    localparam int OUT_W     = 24;
    localparam int STEP_W    = 16;
    localparam int STEP_NUM  = 12;
    localparam int STEPS_W   = STEP_W * STEP_NUM;
    localparam int NOTE_MAX  = 127;
    localparam int SEMIS_OCT = 12;

    localparam logic [CNT_W-1:0] ITER_OCT   = CNT_W'(NUM_W);
    localparam logic [CNT_W-1:0] ITER_SMALL = CNT_W'(NOTE_W);

    localparam logic signed [IW-1:0] ABS_MAX = IW'(8388607);
    localparam logic signed [IW-1:0] ABS_MIN = IW'(-8388608);

    localparam logic [2:0] REG_STEP_COUNT  = 3'd0;
    localparam logic [2:0] REG_ROOT_CLASS  = 3'd1;
    localparam logic [2:0] REG_OCTAVE_SIZE = 3'd2;
    localparam logic [2:0] REG_STEPS_LOW   = 3'd3;
    localparam logic [2:0] REG_STEPS_MID   = 3'd4;
    localparam logic [2:0] REG_STEPS_HIGH  = 3'd5;

    localparam logic [3:0]  STEP_COUNT_RST  = 4'd7;
    localparam logic [3:0]  ROOT_CLASS_RST  = 4'd0;
    localparam logic [15:0] OCTAVE_SIZE_RST = 16'd19200;
    localparam logic [63:0] STEPS_LOW_RST   = 64'd2251827301685657600;
    localparam logic [63:0] STEPS_MID_RST   = 64'd75592368139200;
    localparam logic [63:0] STEPS_HIGH_RST  = 64'd0;

    localparam logic CMD_QUANTIZE = 1'b0;
    localparam logic CMD_DEGREE   = 1'b1;

    typedef struct packed {
        logic [3:0]         step_count;
        logic [3:0]         root_class;
        logic [15:0]        octave_size;
        logic [STEPS_W-1:0] steps;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [NUM_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVB,
        ST_SEARCH,
        ST_DIVD,
        ST_DEGM,
        ST_ROUND,
        ST_NOTEW,
        ST_EMIT
    } state_t;

    function automatic logic [STEP_W-1:0] step_at(input logic [STEPS_W-1:0] steps,
                                                  input logic [3:0] idx);
        logic [STEP_W-1:0] val;
        val = '0;
        if (idx < 4'(STEP_NUM))
        begin
            val = steps[{idx, 4'b0000} +: STEP_W];
        end
        return val;
    endfunction

endpackage

@@ design/spr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_cfg
// Scale configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module spr_cfg
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    output cfg_t        cfg
);

    logic [3:0]  step_count_reg;
    logic [3:0]  root_class_reg;
    logic [15:0] octave_size_reg;
    logic [63:0] steps_low_reg;
    logic [63:0] steps_mid_reg;
    logic [63:0] steps_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= STEP_COUNT_RST;
            root_class_reg  <= ROOT_CLASS_RST;
            octave_size_reg <= OCTAVE_SIZE_RST;
            steps_low_reg   <= STEPS_LOW_RST;
            steps_mid_reg   <= STEPS_MID_RST;
            steps_high_reg  <= STEPS_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_STEP_COUNT:  step_count_reg  <= cfg_data[3:0];
                REG_ROOT_CLASS:  root_class_reg  <= cfg_data[3:0];
                REG_OCTAVE_SIZE: octave_size_reg <= cfg_data[15:0];
                REG_STEPS_LOW:   steps_low_reg   <= cfg_data;
                REG_STEPS_MID:   steps_mid_reg   <= cfg_data;
                REG_STEPS_HIGH:  steps_high_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.step_count  = step_count_reg;
    assign cfg.root_class  = root_class_reg;
    assign cfg.octave_size = octave_size_reg;
    assign cfg.steps       = {steps_high_reg, steps_mid_reg, steps_low_reg};

endmodule

@@ design/spr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_div
// Shared restoring divider, one quotient bit per cycle, quotient bits taken
// from one below a caller-chosen count down to zero.
// ----------------------------------------------------------------------------
module spr_div
    import spr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DW = NUM_W + DEN_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DW-1:0]    trial;

    assign trial = {{DEN_W{1'b0}}, rem_reg} - ({{NUM_W{1'b0}}, den_reg} << k_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            k_next    = req.iters - CNT_W'(1);
            rem_next  = req.num;
            quo_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[DW-1])
            begin
                rem_next       = trial[NUM_W-1:0];
                quo_next[k_reg] = 1'b1;
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ design/scale_pitch_resolver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_pitch_resolver_unit
// Maps a MIDI pitch onto the nearest tone of a configured scale, or a scale
// degree onto its pitch, and rounds the result to a MIDI note.
// Input stream: s_axis_tuser is the command (0 quantize, 1 degree), tdata
// carries pitch, degree and base octave. One transfer in gives one transfer
// out on m_axis: note, offset and absolute pitch in cents, FRAC_BITS fraction bits.
// The scale is set through cfg_we / cfg_addr / cfg_data, and the user must
// write it only while no item is in flight: the block does not enforce this.
// Writes to unused indexes are dropped. One item at a time: s_axis_tready is
// high only while the sequencer idles. Quantize runs set-up, the octave
// division, a search of three octaves of candidates, rounding and the result
// load; degree runs set-up, the degree division, the octave and step sum,
// rounding and the load. An empty scale, or a zero octave for quantize, goes
// from set-up to rounding; a note clamped at either end skips the rounding
// division. The next transfer in is taken in the cycle after the result loads.
// A result sits in the output register until taken; the next item is accepted
// meanwhile and is held at its end while the receiver stalls.
// Reset clears the handshake state and loads a major scale on C with a
// 1200 cent octave.
// ----------------------------------------------------------------------------
module scale_pitch_resolver_unit
    import spr_pkg::*;
#(
    parameter int MAX_STEPS = 12,
    parameter int FRAC_BITS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pitch[6:0], degree[13:7], base_octave[17:14]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // note[6:0], offset[30:7], abs_cents[54:31]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);

    localparam logic [IW-1:0] SEMI     = IW'(100 << FRAC_BITS);
    localparam logic [IW-1:0] HALF     = IW'(50 << FRAC_BITS);
    localparam logic [IW-1:0] NOTE_LIM = IW'((NOTE_MAX + 1) * (100 << FRAC_BITS));

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t state_reg, state_next;

    logic                    cmd_reg, cmd_next;
    logic [6:0]              pitch_reg, pitch_next;
    logic [6:0]              degree_reg, degree_next;
    logic [3:0]              boct_reg, boct_next;
    logic signed [IW-1:0]    pc_reg, pc_next;
    logic                    neg_reg, neg_next;
    logic signed [IW-1:0]    acc_reg, acc_next;
    logic signed [IW-1:0]    best_reg, best_next;
    logic [IW-1:0]           bestd_reg, bestd_next;
    logic                    have_reg, have_next;
    logic [3:0]              idx_reg, idx_next;
    logic [1:0]              ocnt_reg, ocnt_next;
    logic [6:0]              oc_reg, oc_next;
    logic signed [IW-1:0]    abs_reg, abs_next;
    logic [NOTE_W-1:0]       note_reg, note_next;
    logic                    out_valid_reg, out_valid_next;
    logic [NOTE_W-1:0]       out_note_reg, out_note_next;
    logic [OUT_W-1:0]        out_off_reg, out_off_next;
    logic [OUT_W-1:0]        out_abs_reg, out_abs_next;

    logic [3:0]              n_used;
    logic [3:0]              rc_mod;
    logic [7:0]              root_note;
    logic signed [IW-1:0]    pc_val;
    logic signed [IW-1:0]    rootq_val;
    logic signed [IW-1:0]    qnum;
    logic signed [IW-1:0]    qmag;
    logic [DEN_W-1:0]        rfloor;
    logic [STEP_W-1:0]       step_val;
    logic signed [IW-1:0]    cand;
    logic signed [IW-1:0]    diff;
    logic [IW-1:0]           cand_dist;
    logic [22:0]             oc_prod;
    logic signed [IW-1:0]    absc;
    logic signed [IW-1:0]    xr;
    logic signed [IW-1:0]    off_val;

    spr_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    spr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign n_used    = (5'(cfg.step_count) > 5'(MAX_STEPS)) ? 4'(MAX_STEPS) : cfg.step_count;
    assign rc_mod    = (cfg.root_class >= 4'(SEMIS_OCT)) ? cfg.root_class - 4'(SEMIS_OCT)
                                                         : cfg.root_class;
    assign root_note = ({4'b0000, boct_reg} + 8'd1) * 8'(SEMIS_OCT) + {4'b0000, cfg.root_class};
    assign pc_val    = $signed(IW'(pitch_reg) * SEMI);
    assign rootq_val = $signed(IW'(rc_mod) * SEMI);
    assign qnum      = pc_val - rootq_val;
    assign qmag      = qnum[IW-1] ? -qnum : qnum;
    assign rfloor    = (neg_reg && (div_rsp.rem != '0))
                       ? cfg.octave_size - div_rsp.rem[DEN_W-1:0]
                       : div_rsp.rem[DEN_W-1:0];
    assign step_val  = step_at(cfg.steps, idx_reg);
    assign cand      = acc_reg + $signed(IW'(step_val));
    assign diff      = cand - pc_reg;
    assign cand_dist = diff[IW-1] ? IW'(-diff) : IW'(diff);
    assign oc_prod   = 23'(oc_reg) * 23'(cfg.octave_size);
    assign absc      = (abs_reg > ABS_MAX) ? ABS_MAX : ((abs_reg < ABS_MIN) ? ABS_MIN : abs_reg);
    assign xr        = absc + $signed(HALF);
    assign off_val   = abs_reg - $signed(IW'(note_reg) * SEMI);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pitch_next     = pitch_reg;
        degree_next    = degree_reg;
        boct_next      = boct_reg;
        pc_next        = pc_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        bestd_next     = bestd_reg;
        have_next      = have_reg;
        idx_next       = idx_reg;
        ocnt_next      = ocnt_reg;
        oc_next        = oc_reg;
        abs_next       = abs_reg;
        note_next      = note_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_note_next  = out_note_reg;
        out_off_next   = out_off_reg;
        out_abs_next   = out_abs_reg;
        div_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next    = s_axis_tuser;
                    pitch_next  = s_axis_tdata[6:0];
                    degree_next = s_axis_tdata[13:7];
                    boct_next   = s_axis_tdata[17:14];
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (cmd_reg == CMD_QUANTIZE)
                begin
                    pc_next = pc_val;
                    if ((n_used == '0) || (cfg.octave_size == '0))
                    begin
                        abs_next   = pc_val;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = NUM_W'(qmag);
                        div_req.den   = cfg.octave_size;
                        div_req.iters = ITER_OCT;
                        neg_next      = qnum[IW-1];
                        state_next    = ST_DIVB;
                    end
                end
                else
                begin
                    abs_next = $signed(IW'(root_note) * SEMI);
                    if (n_used == '0)
                    begin
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = (degree_reg == '0) ? '0 : NUM_W'(degree_reg - 7'd1);
                        div_req.den   = DEN_W'(n_used);
                        div_req.iters = ITER_SMALL;
                        state_next    = ST_DIVD;
                    end
                end
            end
            ST_DIVB:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = pc_reg - $signed(IW'(rfloor)) - $signed(IW'(cfg.octave_size));
                    idx_next   = '0;
                    ocnt_next  = '0;
                    have_next  = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!have_reg || (cand_dist < bestd_reg))
                begin
                    best_next  = cand;
                    bestd_next = cand_dist;
                    have_next  = 1'b1;
                end
                if (idx_reg == n_used - 4'd1)
                begin
                    idx_next  = '0;
                    acc_next  = acc_reg + $signed(IW'(cfg.octave_size));
                    ocnt_next = ocnt_reg + 2'd1;
                    if (ocnt_reg == 2'd2)
                    begin
                        abs_next   = best_next;
                        state_next = ST_ROUND;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_DIVD:
            begin
                if (div_rsp.done)
                begin
                    idx_next   = div_rsp.rem[3:0];
                    oc_next    = div_rsp.quo[6:0];
                    state_next = ST_DEGM;
                end
            end
            ST_DEGM:
            begin
                abs_next   = abs_reg + $signed(IW'(oc_prod)) + $signed(IW'(step_val));
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                abs_next = absc;
                if (xr[IW-1])
                begin
                    note_next  = '0;
                    state_next = ST_EMIT;
                end
                else if (xr >= $signed(NOTE_LIM))
                begin
                    note_next  = NOTE_W'(NOTE_MAX);
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(xr);
                    div_req.den   = DEN_W'(SEMI);
                    div_req.iters = ITER_SMALL;
                    state_next    = ST_NOTEW;
                end
            end
            ST_NOTEW:
            begin
                if (div_rsp.done)
                begin
                    note_next  = div_rsp.quo[NOTE_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_note_next  = note_reg;
                    out_off_next   = off_val[OUT_W-1:0];
                    out_abs_next   = abs_reg[OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            idx_reg       <= '0;
            ocnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            idx_reg       <= idx_next;
            ocnt_reg      <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pitch_reg    <= pitch_next;
        degree_reg   <= degree_next;
        boct_reg     <= boct_next;
        pc_reg       <= pc_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        bestd_reg    <= bestd_next;
        oc_reg       <= oc_next;
        abs_reg      <= abs_next;
        note_reg     <= note_next;
        out_note_reg <= out_note_next;
        out_off_reg  <= out_off_next;
        out_abs_reg  <= out_abs_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_abs_reg, out_off_reg, out_note_reg};

endmodule
